[sv/l3si_pkg.sv]
// Layer III side information unpacker: shared types, codes and field widths.
// No dependencies; used by l3si_front, l3si_back and the top level.
package l3si_pkg;

  typedef enum logic [4:0] {
    K_MAIN_BEGIN    = 5'd0,
    K_PRIVATE       = 5'd1,
    K_SCFSI         = 5'd2,
    K_PART23_LEN    = 5'd3,
    K_BIG_VALUES    = 5'd4,
    K_GAIN          = 5'd5,
    K_SF_COMPRESS   = 5'd6,
    K_WINSWITCH     = 5'd7,
    K_BLOCK_TYPE    = 5'd8,
    K_MIXED         = 5'd9,
    K_TABLE_SEL     = 5'd10,
    K_SUBBLOCK_GAIN = 5'd11,
    K_REGION0       = 5'd12,
    K_REGION1       = 5'd13,
    K_PREFLAG       = 5'd14,
    K_SF_SCALE      = 5'd15,
    K_COUNT1_SEL    = 5'd16
  } kind_t;

  // implied zero-valued fields still to be sent
  typedef enum logic [3:0] {
    P_NONE = 4'b0001,
    P_BT   = 4'b0010,
    P_MIX  = 4'b0100,
    P_TS2  = 4'b1000
  } pend_t;

  typedef struct packed {
    logic is_mpeg1;
    logic is_stereo;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] side_byte;
    logic       first_byte;
  } head_t;

  localparam cfg_t CFG_RESET = '{is_mpeg1: 1'b1, is_stereo: 1'b1};

  localparam logic [0:0] REG_IS_MPEG1  = 1'b0;
  localparam logic [0:0] REG_IS_STEREO = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  function automatic logic [3:0] width_of(kind_t k, cfg_t c);
    logic [3:0] w;
    case (k)
      K_MAIN_BEGIN:    w = c.is_mpeg1 ? 4'd9 : 4'd8;
      K_PRIVATE: begin
        if (c.is_stereo) w = c.is_mpeg1 ? 4'd3 : 4'd2;
        else             w = c.is_mpeg1 ? 4'd5 : 4'd1;
      end
      K_PART23_LEN:    w = 4'd12;
      K_BIG_VALUES:    w = 4'd9;
      K_GAIN:          w = 4'd8;
      K_SF_COMPRESS:   w = c.is_mpeg1 ? 4'd4 : 4'd9;
      K_BLOCK_TYPE:    w = 4'd2;
      K_TABLE_SEL:     w = 4'd5;
      K_SUBBLOCK_GAIN: w = 4'd3;
      K_REGION0:       w = 4'd4;
      K_REGION1:       w = 4'd3;
      default:         w = 4'd1;
    endcase
    return w;
  endfunction

endpackage

[sv/l3si_if.sv]
// Valid/ready channels of the side information unpacker: byte beats in,
// field beats out. No dependencies.
interface l3si_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] side_byte;
  logic       first_byte;
  modport source (output valid, side_byte, first_byte, input ready);
  modport sink   (input valid, side_byte, first_byte, output ready);
endinterface

interface l3si_field_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_kind;
  logic        granule;
  logic        channel;
  logic [1:0]  field_index;
  logic [11:0] field_value;
  logic        last_field;
  modport source (output valid, field_kind, granule, channel, field_index, field_value,
                  last_field, input ready);
  modport sink   (input valid, field_kind, granule, channel, field_index, field_value,
                  last_field, output ready);
endinterface

[sv/l3si_front.sv]
// Front end: takes byte beats and holds them in a short queue for the parser.
// Depends on l3si_pkg and l3si_byte_if.
module l3si_front (
  input  logic                 clk,
  input  logic                 rst,
  l3si_byte_if.sink            bytes,
  output l3si_pkg::head_t      head,
  input  logic                 pop
);

  logic [8:0]              mem [l3si_pkg::QUEUE_DEPTH];
  logic [l3si_pkg::QPTR_W-1:0] wr_ptr;
  logic [l3si_pkg::QPTR_W-1:0] rd_ptr;
  logic [l3si_pkg::QPTR_W:0]   count;
  logic                    push;
  logic                    take;

  assign bytes.ready = (count != (l3si_pkg::QPTR_W+1)'(l3si_pkg::QUEUE_DEPTH));
  assign push        = bytes.valid && bytes.ready;
  assign take        = pop && (count != '0);

  assign head = '{valid:      (count != '0),
                  side_byte:  mem[rd_ptr][8:1],
                  first_byte: mem[rd_ptr][0]};

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= {bytes.side_byte, bytes.first_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (take) rd_ptr <= rd_ptr + 1'b1;
      case ({push, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/l3si_back.sv]
// Back end: bit-serial field parser and output register, taking one bit or
// one implied field per cycle unless stalled; uses l3si_pkg, l3si_field_if.
module l3si_back (
  input  logic                 clk,
  input  logic                 rst,
  input  l3si_pkg::cfg_t       cfg,
  input  l3si_pkg::head_t      head,
  output logic                 pop,
  l3si_field_if.source         fields
);

  l3si_pkg::kind_t step_index, step_index_next;
  logic [3:0]      bits_left, bits_left_next;
  logic [11:0]     acc, acc_next;
  logic            gr, gr_next;
  logic            ch, ch_next;
  logic [1:0]      arr_idx, arr_idx_next;
  logic            sw, sw_next;
  logic            done, done_next;
  l3si_pkg::pend_t pend, pend_next;
  logic [2:0]      bit_pos, bit_pos_next;

  logic            out_valid;
  logic [4:0]      o_kind;
  logic            o_gr;
  logic            o_ch;
  logic [1:0]      o_idx;
  logic [11:0]     o_val;
  logic            o_last;

  logic            slot_free;
  logic            load;
  logic [4:0]      l_kind;
  logic [1:0]      l_idx;
  logic [11:0]     l_val;
  logic            l_last;

  assign slot_free = !out_valid || fields.ready;

  assign fields.valid       = out_valid;
  assign fields.field_kind  = o_kind;
  assign fields.granule     = o_gr;
  assign fields.channel     = o_ch;
  assign fields.field_index = o_idx;
  assign fields.field_value = o_val;
  assign fields.last_field  = o_last;

  always_comb begin
    l3si_pkg::kind_t e_step;
    l3si_pkg::kind_t nk;
    logic [3:0]      e_bits;
    logic [11:0]     e_acc;
    logic            e_gr;
    logic            e_ch;
    logic [1:0]      e_idx;
    logic            e_sw;
    logic            e_done;
    logic            bitv;
    logic [11:0]     v;
    logic            do_begin;
    logic [1:0]      n_idx;

    step_index_next = step_index;
    bits_left_next  = bits_left;
    acc_next        = acc;
    gr_next         = gr;
    ch_next         = ch;
    arr_idx_next    = arr_idx;
    sw_next         = sw;
    done_next       = done;
    pend_next       = pend;
    bit_pos_next    = bit_pos;
    pop             = 1'b0;
    load            = 1'b0;
    l_kind          = 5'd0;
    l_idx           = 2'd0;
    l_val           = 12'd0;
    l_last          = 1'b0;
    nk              = l3si_pkg::K_MAIN_BEGIN;
    n_idx           = 2'd0;
    do_begin        = 1'b0;

    // restart on a first byte, before its first bit
    if (head.first_byte && bit_pos == 3'd7) begin
      e_step = l3si_pkg::K_MAIN_BEGIN;
      e_bits = l3si_pkg::width_of(l3si_pkg::K_MAIN_BEGIN, cfg);
      e_acc  = 12'd0;
      e_gr   = 1'b0;
      e_ch   = 1'b0;
      e_idx  = 2'd0;
      e_sw   = 1'b0;
      e_done = 1'b0;
    end else begin
      e_step = step_index;
      e_bits = bits_left;
      e_acc  = acc;
      e_gr   = gr;
      e_ch   = ch;
      e_idx  = arr_idx;
      e_sw   = sw;
      e_done = done;
    end
    bitv = head.side_byte[bit_pos];
    v    = {e_acc[10:0], bitv};

    if (pend != l3si_pkg::P_NONE) begin
      if (slot_free) begin
        load = 1'b1;
        unique case (pend)
          l3si_pkg::P_BT: begin
            l_kind    = l3si_pkg::K_BLOCK_TYPE;
            pend_next = l3si_pkg::P_MIX;
          end
          l3si_pkg::P_MIX: begin
            l_kind    = l3si_pkg::K_MIXED;
            pend_next = l3si_pkg::P_NONE;
          end
          l3si_pkg::P_TS2: begin
            l_kind    = l3si_pkg::K_TABLE_SEL;
            l_idx     = 2'd2;
            pend_next = l3si_pkg::P_NONE;
          end
          default: pend_next = l3si_pkg::P_NONE;
        endcase
      end
    end else if (head.valid) begin
      if (e_done) begin
        // block complete: drop the whole byte
        pop             = 1'b1;
        bit_pos_next    = 3'd7;
        step_index_next = e_step;
        bits_left_next  = e_bits;
        acc_next        = e_acc;
        gr_next         = e_gr;
        ch_next         = e_ch;
        arr_idx_next    = e_idx;
        sw_next         = e_sw;
        done_next       = e_done;
      end else if (e_bits != 4'd1 || slot_free) begin
        step_index_next = e_step;
        bits_left_next  = e_bits - 4'd1;
        acc_next        = v;
        gr_next         = e_gr;
        ch_next         = e_ch;
        arr_idx_next    = e_idx;
        sw_next         = e_sw;
        done_next       = e_done;
        if (e_bits == 4'd1) begin
          load   = 1'b1;
          l_kind = e_step;
          l_val  = v;
          if (e_step == l3si_pkg::K_COUNT1_SEL && e_ch >= cfg.is_stereo &&
              e_gr >= cfg.is_mpeg1) begin
            l_last         = 1'b1;
            done_next      = 1'b1;
            acc_next       = 12'd0;
            bits_left_next = 4'd0;
          end else begin
            if (e_step == l3si_pkg::K_SCFSI || e_step == l3si_pkg::K_TABLE_SEL ||
                e_step == l3si_pkg::K_SUBBLOCK_GAIN) begin
              l_idx = e_idx;
            end
            do_begin = 1'b1;
            case (e_step)
              l3si_pkg::K_PRIVATE: begin
                if (cfg.is_mpeg1) begin
                  ch_next = 1'b0;
                  nk      = l3si_pkg::K_SCFSI;
                end else begin
                  nk = l3si_pkg::K_PART23_LEN;
                end
              end
              l3si_pkg::K_SCFSI: begin
                if (e_idx != 2'd3) begin
                  nk    = l3si_pkg::K_SCFSI;
                  n_idx = e_idx + 2'd1;
                end else if (e_ch < cfg.is_stereo) begin
                  ch_next = 1'b1;
                  nk      = l3si_pkg::K_SCFSI;
                end else begin
                  ch_next = 1'b0;
                  nk      = l3si_pkg::K_PART23_LEN;
                end
              end
              l3si_pkg::K_WINSWITCH: begin
                sw_next = v[0];
                if (v[0]) begin
                  nk = l3si_pkg::K_BLOCK_TYPE;
                end else begin
                  pend_next = l3si_pkg::P_BT;
                  nk        = l3si_pkg::K_TABLE_SEL;
                end
              end
              l3si_pkg::K_TABLE_SEL: begin
                if (e_sw) begin
                  if (e_idx == 2'd0) begin
                    nk    = l3si_pkg::K_TABLE_SEL;
                    n_idx = 2'd1;
                  end else begin
                    pend_next = l3si_pkg::P_TS2;
                    nk        = l3si_pkg::K_SUBBLOCK_GAIN;
                  end
                end else if (e_idx < 2'd2) begin
                  nk    = l3si_pkg::K_TABLE_SEL;
                  n_idx = e_idx + 2'd1;
                end else begin
                  nk = l3si_pkg::K_REGION0;
                end
              end
              l3si_pkg::K_SUBBLOCK_GAIN: begin
                if (e_idx < 2'd2) begin
                  nk    = l3si_pkg::K_SUBBLOCK_GAIN;
                  n_idx = e_idx + 2'd1;
                end else begin
                  nk = cfg.is_mpeg1 ? l3si_pkg::K_PREFLAG : l3si_pkg::K_SF_SCALE;
                end
              end
              l3si_pkg::K_REGION1: begin
                nk = cfg.is_mpeg1 ? l3si_pkg::K_PREFLAG : l3si_pkg::K_SF_SCALE;
              end
              l3si_pkg::K_COUNT1_SEL: begin
                if (e_ch < cfg.is_stereo) begin
                  ch_next = 1'b1;
                end else begin
                  ch_next = 1'b0;
                  gr_next = ~e_gr;
                end
                nk = l3si_pkg::K_PART23_LEN;
              end
              default: nk = l3si_pkg::kind_t'(e_step + 5'd1);
            endcase
          end
        end
        if (do_begin) begin
          step_index_next = nk;
          arr_idx_next    = n_idx;
          acc_next        = 12'd0;
          bits_left_next  = l3si_pkg::width_of(nk, cfg);
        end
        bit_pos_next = bit_pos - 3'd1;
        if (bit_pos == 3'd0 || done_next) begin
          pop          = 1'b1;
          bit_pos_next = 3'd7;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index <= l3si_pkg::K_MAIN_BEGIN;
      bits_left  <= l3si_pkg::width_of(l3si_pkg::K_MAIN_BEGIN, l3si_pkg::CFG_RESET);
      acc        <= 12'd0;
      gr         <= 1'b0;
      ch         <= 1'b0;
      arr_idx    <= 2'd0;
      sw         <= 1'b0;
      done       <= 1'b0;
      pend       <= l3si_pkg::P_NONE;
      bit_pos    <= 3'd7;
      out_valid  <= 1'b0;
    end else begin
      step_index <= step_index_next;
      bits_left  <= bits_left_next;
      acc        <= acc_next;
      gr         <= gr_next;
      ch         <= ch_next;
      arr_idx    <= arr_idx_next;
      sw         <= sw_next;
      done       <= done_next;
      pend       <= pend_next;
      bit_pos    <= bit_pos_next;
      if (load)              out_valid <= 1'b1;
      else if (fields.ready) out_valid <= 1'b0;
    end
  end

  // granule and channel of a field are those before the counters advance
  always_ff @(posedge clk) begin
    if (load) begin
      o_kind <= l_kind;
      o_gr   <= (pend != l3si_pkg::P_NONE) ? gr : (head.first_byte && bit_pos == 3'd7)
                ? 1'b0 : gr;
      o_ch   <= (pend != l3si_pkg::P_NONE) ? ch : (head.first_byte && bit_pos == 3'd7)
                ? 1'b0 : ch;
      o_idx  <= l_idx;
      o_val  <= l_val;
      o_last <= l_last;
    end
  end

endmodule

[sv/layer3_side_info_unpacker.sv]
// Top level of the Layer III side information unpacker: configuration
// registers, byte queue front end and bit-serial parser back end.
// Depends on l3si_pkg, l3si_if, l3si_front and l3si_back.
//
// Usage: side information bytes enter on the bytes channel, one byte a beat,
// with first_byte set on the first byte of each frame's block; that byte
// restarts the parse. Tagged fields leave on the fields channel, one a beat,
// last_field marking the final field of the block. Bytes after the block is
// complete produce nothing until the next first byte.
// Configuration: cfg_we with cfg_index 0 writes is_mpeg1, index 1 is_stereo,
// from bit 0 of cfg_data; write only while the block is idle.
// Throughput: the parser consumes one bit per cycle unless stalled, and sends
// each implied zero field as a step of its own (block type and mixed flag after
// a clear window switching flag, third table select when it is set).
// Path: a byte passes through the queue, its bits are parsed from the queue
// head, and each completed field is registered in the output register.
// A four-byte queue lets bytes arrive while the parser works; the output
// register holds a field while the receiver stalls, and the parser then waits only
// when it has another field to present. Reset empties the queue, clears the
// output and restores MPEG-1 stereo with the parse at main data begin.
module layer3_side_info_unpacker (
  input  logic         clk,
  input  logic         rst,
  l3si_byte_if.sink    bytes,
  l3si_field_if.source fields,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [0:0]   cfg_data
);

  l3si_pkg::cfg_t  cfg;
  l3si_pkg::head_t head;
  logic            pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= l3si_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        l3si_pkg::REG_IS_MPEG1:  cfg.is_mpeg1  <= cfg_data[0];
        l3si_pkg::REG_IS_STEREO: cfg.is_stereo <= cfg_data[0];
        default: cfg <= cfg;
      endcase
    end
  end

  l3si_front u_front (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .head  (head),
    .pop   (pop)
  );

  l3si_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .pop    (pop),
    .fields (fields)
  );

endmodule
